FILE: hdl/pidaw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, register indexes and Q16.16 helpers for the PID controller
// with integral clamp.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   // fraction bits of the Q16.16 format
   localparam int QFRAC = 16;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_GAIN_P       = 3'd0,
      REG_GAIN_I       = 3'd1,
      REG_GAIN_D       = 3'd2,
      REG_STEP_TIME    = 3'd3,
      REG_WINDUP_LIMIT = 3'd4,
      REG_MIN_OUTPUT   = 3'd5,
      REG_MAX_OUTPUT   = 3'd6
   } pidaw_reg_type;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_ERR    = 9'b000000010,
      ST_MUL    = 9'b000000100,
      ST_RND    = 9'b000001000,
      ST_DIVST  = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_DIVEND = 9'b001000000,
      ST_SUM    = 9'b010000000,
      ST_HOLD   = 9'b100000000
   } pidaw_state_type;

   // which product the shared multiplier is forming
   typedef enum logic [1:0] {
      OP_DT = 2'd0,
      OP_P  = 2'd1,
      OP_I  = 2'd2,
      OP_D  = 2'd3
   } pidaw_op_type;

   // magnitude of a signed 32-bit value (most negative gives 2^31)
   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      logic [31:0] r;
      r = a[31] ? 32'(-a) : 32'(a);
      return r;
   endfunction

   // signed result from sign and magnitude, saturated to 32 bits
   function automatic logic signed [31:0] sat_mag(input logic neg,
                                                  input logic [47:0] m);
      logic signed [31:0] r;
      logic               big;
      big = |m[47:31];
      if (neg) begin
         r = big ? 32'sh8000_0000 : 32'(-m[31:0]);
      end else begin
         r = big ? 32'sh7FFF_FFFF : 32'(m[31:0]);
      end
      return r;
   endfunction

   // round a Q32.32 product magnitude to Q16.16, half away from zero
   function automatic logic [47:0] qround(input logic [63:0] p);
      logic [63:0] t;
      t = p + 64'(1 << (QFRAC - 1));
      return t[63:QFRAC];
   endfunction

   // saturate a 34-bit signed sum to 32 bits
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/pid_controller_antiwindup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_core
// PID step in signed Q16.16 with integral clamp and output clamp.
// A new request is taken only in the idle state, once the previous result
// has been loaded into the output register. Each step runs the restoring
// divider for the derivative and makes four passes through the shared
// 32x32 multiplier.
// Reset: synchronous, active high; registers take their reset values, the
// integral and previous error clear, and no result is pending.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_core
   import pidaw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] setpoint, [63:32] measured_value
   input  logic        req_tuser,   // [0] restart
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] drive_value
   output logic        rsp_tuser,   // [0] output_clamped
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff, min_out_ff, max_out_ff;
   logic [30:0]        step_time_ff, windup_ff;

   // sequencer and datapath registers
   pidaw_state_type    state_ff, state_in;
   pidaw_op_type       op_ff, op_in;
   logic signed [31:0] setpoint_ff, setpoint_in, measured_ff, measured_in;
   logic signed [31:0] err_ff, err_in, integral_ff, integral_in;
   logic signed [31:0] last_err_ff, last_err_in, deriv_ff, deriv_in;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] acc_ff, acc_in;
   logic [30:0]        rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               dneg_ff, dneg_in, dovf_ff, dovf_in;
   logic               rsp_valid_ff, rsp_valid_in, clamped_ff, clamped_in;
   logic signed [31:0] drive_ff, drive_in;

   // combinational helpers
   logic [30:0]        dt;
   logic signed [31:0] wl_s;
   logic signed [32:0] err_w, diff_w;
   logic signed [31:0] diff_sat, q_w, isum, fsum;
   logic [31:0]        ma, mb, dmag, r2, rsub;
   logic [63:0]        prod_w;
   logic [47:0]        num_w;
   logic               r_ge;

   // a zero period acts as the smallest period
   assign dt   = (step_time_ff == 31'd0) ? 31'd1 : step_time_ff;
   assign wl_s = signed'({1'b0, windup_ff});

   // shared multiplier operand select
   always_comb begin
      unique case (op_ff)
         OP_DT: begin
            ma     = mag32(err_ff);
            mb     = {1'b0, dt};
            neg_in = err_ff[31];
         end
         OP_P: begin
            ma     = mag32(gain_p_ff);
            mb     = mag32(err_ff);
            neg_in = gain_p_ff[31] ^ err_ff[31];
         end
         OP_I: begin
            ma     = mag32(gain_i_ff);
            mb     = mag32(integral_ff);
            neg_in = gain_i_ff[31] ^ integral_ff[31];
         end
         OP_D: begin
            ma     = mag32(gain_d_ff);
            mb     = mag32(deriv_ff);
            neg_in = gain_d_ff[31] ^ deriv_ff[31];
         end
         default: begin
            ma     = 32'd0;
            mb     = 32'd0;
            neg_in = 1'b0;
         end
      endcase
   end

   assign prod_w = 64'(ma) * 64'(mb);
   assign q_w    = sat_mag(neg_ff, qround(prod_ff));

   // error and error difference
   assign err_w    = 33'(setpoint_ff) - 33'(measured_ff);
   assign diff_w   = 33'(err_ff) - 33'(last_err_ff);
   assign diff_sat = sat34(34'(diff_w));
   assign dmag     = mag32(diff_sat);
   assign num_w    = {dmag, 16'h0000} + 48'(dt[30:1]);

   // integral update before the windup clamp
   assign isum = sat34(34'(integral_ff) + 34'(q_w));

   // one restoring divider step
   assign r2   = {rem_ff, quo_ff[31]};
   assign r_ge = r2 >= {1'b0, dt};
   assign rsub = r2 - {1'b0, dt};

   // final sum saturated
   assign fsum = sat34(acc_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      setpoint_in = setpoint_ff;
      measured_in = measured_ff;
      err_in      = err_ff;
      integral_in = integral_ff;
      last_err_in = last_err_ff;
      deriv_in    = deriv_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      dneg_in     = dneg_ff;
      dovf_in     = dovf_ff;
      drive_in    = drive_ff;
      clamped_in  = clamped_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               setpoint_in = req_tdata[31:0];
               measured_in = req_tdata[63:32];
               if (req_tuser) begin
                  integral_in = 32'sd0;
                  last_err_in = 32'sd0;
               end
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = sat34(34'(err_w));
            op_in    = OP_DT;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = prod_w;
            state_in = ST_RND;
         end
         ST_RND: begin
            unique case (op_ff)
               OP_DT: begin
                  // windup clamp
                  if (isum > wl_s) begin
                     integral_in = wl_s;
                  end else if (isum < -wl_s) begin
                     integral_in = -wl_s;
                  end else begin
                     integral_in = isum;
                  end
                  state_in = ST_DIVST;
               end
               OP_P: begin
                  acc_in   = 34'(q_w);
                  op_in    = OP_I;
                  state_in = ST_MUL;
               end
               OP_I: begin
                  acc_in   = acc_ff + 34'(q_w);
                  op_in    = OP_D;
                  state_in = ST_MUL;
               end
               default: begin
                  acc_in   = acc_ff + 34'(q_w);
                  state_in = ST_SUM;
               end
            endcase
         end
         ST_DIVST: begin
            // quotient of 2^32 or more saturates outright
            rem_in      = {15'd0, num_w[47:32]};
            quo_in      = num_w[31:0];
            dovf_in     = {15'd0, num_w[47:32]} >= dt;
            dneg_in     = diff_sat[31];
            cnt_in      = 5'd31;
            last_err_in = err_ff;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            rem_in = r_ge ? rsub[30:0] : r2[30:0];
            quo_in = {quo_ff[30:0], r_ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            deriv_in = sat_mag(dneg_ff, dovf_ff ? 48'h0001_0000_0000 : {16'd0, quo_ff});
            op_in    = OP_P;
            state_in = ST_MUL;
         end
         ST_SUM: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               priority if (fsum > max_out_ff) begin
                  drive_in   = max_out_ff;
                  clamped_in = 1'b1;
               end else if (fsum < min_out_ff) begin
                  drive_in   = min_out_ff;
                  clamped_in = 1'b1;
               end else begin
                  drive_in   = fsum;
                  clamped_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DT;
         integral_ff  <= 32'sd0;
         last_err_ff  <= 32'sd0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 5'd0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         integral_ff  <= integral_in;
         last_err_ff  <= last_err_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      setpoint_ff <= setpoint_in;
      measured_ff <= measured_in;
      err_ff      <= err_in;
      deriv_ff    <= deriv_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dneg_ff     <= dneg_in;
      dovf_ff     <= dovf_in;
      drive_ff    <= drive_in;
      clamped_ff  <= clamped_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 32'sd0;
         gain_i_ff    <= 32'sd0;
         gain_d_ff    <= 32'sd0;
         step_time_ff <= 31'd655;
         windup_ff    <= 31'd65536;
         min_out_ff   <= 32'sd0;
         max_out_ff   <= 32'sd65536;
      end else if (csr_we) begin
         unique case (pidaw_reg_type'(csr_addr))
            REG_GAIN_P:       gain_p_ff    <= csr_wdata;
            REG_GAIN_I:       gain_i_ff    <= csr_wdata;
            REG_GAIN_D:       gain_d_ff    <= csr_wdata;
            REG_STEP_TIME:    step_time_ff <= csr_wdata[30:0];
            REG_WINDUP_LIMIT: windup_ff    <= csr_wdata[30:0];
            REG_MIN_OUTPUT:   min_out_ff   <= csr_wdata;
            REG_MAX_OUTPUT:   max_out_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = clamped_ff;

endmodule
